// ===== src/jsbd_pkg.sv =====
// Shared types, codes and helpers for the JSON string body decoder.
`default_nettype none
package jsbd_pkg;

	typedef enum logic [3:0] {
		MODE_PLAIN   = 4'd0,
		MODE_ESC     = 4'd1,
		MODE_HEX1    = 4'd2,
		MODE_NEED_BS = 4'd3,
		MODE_NEED_U  = 4'd4,
		MODE_HEX2    = 4'd5,
		MODE_UTF8    = 4'd6
	} mode_t;

	typedef enum logic [2:0] {
		ST_DATA   = 3'd0,
		ST_CLOSED = 3'd1,
		ST_END    = 3'd2,
		ST_CTRL   = 3'd3,
		ST_ESC    = 3'd4,
		ST_UTF8   = 3'd5
	} status_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_CTRL_LIMIT = 8'h20;

	localparam logic [15:0] SURR_HI_MIN = 16'hD800;
	localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
	localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
	localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
	localparam logic [20:0] CP_SUPP_BASE = 21'h10000;
	localparam logic [20:0] CP_MAX       = 21'h10FFFF;

	localparam int MAX_RES = 4;

	typedef struct packed {
		mode_t        mode;
		logic [15:0]  hex_accum;
		logic [1:0]   hex_digits;
		logic [9:0]   high_sur;
		logic [23:0]  held;
		logic [20:0]  code;
		logic [1:0]   remaining;
		logic [2:0]   length;
	} state_t;

	typedef struct packed {
		logic [2:0]                  cnt;
		status_t                     status;
		logic [MAX_RES-1:0][7:0]     bytes;
	} step_res_t;

	// {valid, value}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/jsbd_if.sv =====
// Request and result channel interfaces of the JSON string body decoder.
`default_nettype none
interface jsbd_in_if;
	import jsbd_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;
	modport source(output valid, output in_byte, output end_of_input, input ready);
	modport sink(input valid, input in_byte, input end_of_input, output ready);
endinterface

interface jsbd_out_if;
	import jsbd_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	status_t    status;
	logic       last;
	modport source(output valid, output out_byte, output status, output last, input ready);
	modport sink(input valid, input out_byte, input status, input last, output ready);
endinterface
`default_nettype wire

// ===== src/jsbd_step.sv =====
// Next-state and result group for one request byte.
`default_nettype none
module jsbd_step (
	input  jsbd_pkg::state_t    st,
	input  logic [7:0]          c,
	input  logic                eoi,
	output jsbd_pkg::state_t    st_nxt,
	output jsbd_pkg::step_res_t res
);
	import jsbd_pkg::*;

	logic [4:0]  hv;
	logic [15:0] acc;
	logic [20:0] cp;
	logic        do_enc;
	logic [20:0] u_code;
	logic [1:0]  u_rem;
	logic [20:0] u_min;

	always_comb begin
		st_nxt = st;
		res = '0;
		res.status = ST_DATA;
		cp = '0;
		do_enc = 1'b0;
		hv = hex_value(c);
		acc = {st.hex_accum[11:0], hv[3:0]};
		u_code = {st.code[14:0], c[5:0]};
		u_rem = st.remaining - 2'd1;
		u_min = (st.length == 3'd2) ? 21'h80 : (st.length == 3'd3) ? 21'h800 : CP_SUPP_BASE;
		if (eoi) begin
			st_nxt = '0;
			res.cnt = 3'd1;
			if (st.mode == MODE_NEED_BS || st.mode == MODE_NEED_U) begin
				res.status = ST_ESC;
			end else if (st.mode == MODE_UTF8) begin
				res.status = ST_UTF8;
			end else begin
				res.status = ST_END;
			end
		end else begin
			unique case (st.mode)
				MODE_ESC: begin
					st_nxt.mode = MODE_PLAIN;
					res.cnt = 3'd1;
					case (c)
						CH_QUOTE, CH_BSLASH, CH_SLASH: res.bytes[0] = c;
						CH_B: res.bytes[0] = 8'h08;
						CH_F: res.bytes[0] = 8'h0C;
						CH_N: res.bytes[0] = 8'h0A;
						CH_R: res.bytes[0] = 8'h0D;
						CH_T: res.bytes[0] = 8'h09;
						CH_U: begin
							st_nxt.mode = MODE_HEX1;
							st_nxt.hex_accum = '0;
							st_nxt.hex_digits = '0;
							res.cnt = 3'd0;
						end
						default: begin
							st_nxt = '0;
							res.status = ST_ESC;
						end
					endcase
				end
				MODE_HEX1, MODE_HEX2: begin
					if (!hv[4]) begin
						st_nxt = '0;
						res.cnt = 3'd1;
						res.status = ST_ESC;
					end else if (st.hex_digits != 2'd3) begin
						st_nxt.hex_accum = acc;
						st_nxt.hex_digits = st.hex_digits + 2'd1;
					end else begin
						st_nxt.hex_accum = '0;
						st_nxt.hex_digits = '0;
						if (st.mode == MODE_HEX1) begin
							if (acc >= SURR_HI_MIN && acc <= SURR_HI_MAX) begin
								st_nxt.high_sur = acc[9:0];
								st_nxt.mode = MODE_NEED_BS;
							end else if (acc >= SURR_LO_MIN && acc <= SURR_LO_MAX) begin
								st_nxt = '0;
								res.cnt = 3'd1;
								res.status = ST_ESC;
							end else begin
								cp = {5'd0, acc};
								do_enc = 1'b1;
							end
						end else begin
							if (acc < SURR_LO_MIN || acc > SURR_LO_MAX) begin
								st_nxt = '0;
								res.cnt = 3'd1;
								res.status = ST_ESC;
							end else begin
								cp = CP_SUPP_BASE + {1'b0, st.high_sur, acc[9:0]};
								do_enc = 1'b1;
							end
						end
						if (do_enc) begin
							st_nxt.high_sur = '0;
							st_nxt.mode = MODE_PLAIN;
						end
					end
				end
				MODE_NEED_BS: begin
					if (c != CH_BSLASH) begin
						st_nxt = '0;
						res.cnt = 3'd1;
						res.status = ST_ESC;
					end else begin
						st_nxt.mode = MODE_NEED_U;
					end
				end
				MODE_NEED_U: begin
					if (c != CH_U) begin
						st_nxt = '0;
						res.cnt = 3'd1;
						res.status = ST_ESC;
					end else begin
						st_nxt.mode = MODE_HEX2;
						st_nxt.hex_accum = '0;
						st_nxt.hex_digits = '0;
					end
				end
				MODE_UTF8: begin
					if (c[7:6] != 2'b10) begin
						st_nxt = '0;
						res.cnt = 3'd1;
						res.status = ST_UTF8;
					end else if (u_rem != 2'd0) begin
						st_nxt.code = u_code;
						st_nxt.remaining = u_rem;
						st_nxt.held = {st.held[15:0], c};
					end else begin
						st_nxt = '0;
						res.cnt = 3'd1;
						if (u_code < u_min || u_code > CP_MAX ||
						    (u_code >= {5'd0, SURR_HI_MIN} && u_code <= {5'd0, SURR_LO_MAX})) begin
							res.status = ST_UTF8;
						end else begin
							res.cnt = st.length;
							case (st.length)
								3'd2: res.bytes = {16'd0, c, st.held[7:0]};
								3'd3: res.bytes = {8'd0, c, st.held[7:0], st.held[15:8]};
								default: res.bytes = {c, st.held[7:0], st.held[15:8], st.held[23:16]};
							endcase
						end
					end
				end
				default: begin
					st_nxt.mode = MODE_PLAIN;
					if (c == CH_QUOTE) begin
						st_nxt = '0;
						res.cnt = 3'd1;
						res.status = ST_CLOSED;
					end else if (c == CH_BSLASH) begin
						st_nxt.mode = MODE_ESC;
					end else if (c < CH_CTRL_LIMIT) begin
						st_nxt = '0;
						res.cnt = 3'd1;
						res.status = ST_CTRL;
					end else if (!c[7]) begin
						res.cnt = 3'd1;
						res.bytes[0] = c;
					end else if (c[7:5] == 3'b110) begin
						st_nxt.length = 3'd2;
						st_nxt.remaining = 2'd1;
						st_nxt.code = {16'd0, c[4:0]};
						st_nxt.held = {16'd0, c};
						st_nxt.mode = MODE_UTF8;
					end else if (c[7:4] == 4'b1110) begin
						st_nxt.length = 3'd3;
						st_nxt.remaining = 2'd2;
						st_nxt.code = {17'd0, c[3:0]};
						st_nxt.held = {16'd0, c};
						st_nxt.mode = MODE_UTF8;
					end else if (c[7:3] == 5'b11110) begin
						st_nxt.length = 3'd4;
						st_nxt.remaining = 2'd3;
						st_nxt.code = {18'd0, c[2:0]};
						st_nxt.held = {16'd0, c};
						st_nxt.mode = MODE_UTF8;
					end else begin
						st_nxt = '0;
						res.cnt = 3'd1;
						res.status = ST_UTF8;
					end
				end
			endcase
			if (do_enc) begin
				if (cp < 21'h80) begin
					res.cnt = 3'd1;
					res.bytes[0] = cp[7:0];
				end else if (cp < 21'h800) begin
					res.cnt = 3'd2;
					res.bytes[0] = {3'b110, cp[10:6]};
					res.bytes[1] = {2'b10, cp[5:0]};
				end else if (cp < CP_SUPP_BASE) begin
					res.cnt = 3'd3;
					res.bytes[0] = {4'b1110, cp[15:12]};
					res.bytes[1] = {2'b10, cp[11:6]};
					res.bytes[2] = {2'b10, cp[5:0]};
				end else begin
					res.cnt = 3'd4;
					res.bytes[0] = {5'b11110, cp[20:18]};
					res.bytes[1] = {2'b10, cp[17:12]};
					res.bytes[2] = {2'b10, cp[11:6]};
					res.bytes[3] = {2'b10, cp[5:0]};
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/json_string_body_decoder_core.sv =====
// Top level of the JSON string body decoder.
// The first result of a request is registered and shows in the cycle after the request is taken.
// Throughput: one request per cycle while each gives at most one result and the output
// is not stalled; a request's several results hold the register until the last is taken.
// Requests giving no result (escape prefix, hex digits, partial UTF-8) update only state.
// Reset clears the decoder state and empties the result register.
`default_nettype none
module json_string_body_decoder_core (
	input  logic              clk,
	input  logic              arst_n,
	jsbd_in_if.sink           din,
	jsbd_out_if.source        dout
);
	import jsbd_pkg::*;

	state_t              state_q;
	state_t              st_nxt;
	step_res_t           res;
	logic                valid_s1;
	logic [2:0]          cnt_s1;
	status_t             status_s1;
	logic [MAX_RES-1:0][7:0] bytes_s1;
	logic [1:0]          idx_q;
	logic                last;
	logic                din_acc;
	logic                dout_acc;
	logic                load;

	jsbd_step u_step (
		.st     (state_q),
		.c      (din.in_byte),
		.eoi    (din.end_of_input),
		.st_nxt (st_nxt),
		.res    (res)
	);

	assign last     = ({1'b0, idx_q} == cnt_s1 - 3'd1);
	assign din.ready = !valid_s1 || (dout.ready && last);
	assign din_acc  = din.valid && din.ready;
	assign dout_acc = dout.valid && dout.ready;
	assign load     = din_acc && (res.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (din_acc) state_q <= st_nxt;
			if (load) begin
				valid_s1 <= 1'b1;
				idx_q    <= '0;
			end else if (dout_acc) begin
				if (last) valid_s1 <= 1'b0;
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cnt_s1    <= res.cnt;
			status_s1 <= res.status;
			bytes_s1  <= res.bytes;
		end
	end

	assign dout.valid    = valid_s1;
	assign dout.out_byte = bytes_s1[idx_q];
	assign dout.status   = status_s1;
	assign dout.last     = last;

endmodule
`default_nettype wire

// ===== src/jsbd_checker.sv =====
// Port-level checks for the JSON string body decoder, bound to the top level.
`default_nettype none
module jsbd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       din_valid,
	input logic       din_ready,
	input logic       din_eoi,
	input logic       dout_valid,
	input logic       dout_ready,
	input logic [7:0] dout_byte,
	input logic [2:0] dout_status,
	input logic       dout_last
);
	import jsbd_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dout_valid && !dout_ready |=> dout_valid)
		else $error("result valid dropped before taken");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		dout_valid && !dout_ready |=> $stable(dout_byte) && $stable(dout_status) &&
		$stable(dout_last))
		else $error("stalled result changed");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		dout_valid && dout_status != ST_DATA |-> dout_last)
		else $error("status result not marked last");

	a_eoi_status: assert property (@(posedge clk) disable iff (!arst_n)
		din_valid && din_ready && din_eoi |=>
		dout_valid && dout_last && dout_status != ST_DATA)
		else $error("end of input did not give a status");

endmodule

bind json_string_body_decoder_core jsbd_checker u_jsbd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.din_valid   (din.valid),
	.din_ready   (din.ready),
	.din_eoi     (din.end_of_input),
	.dout_valid  (dout.valid),
	.dout_ready  (dout.ready),
	.dout_byte   (dout.out_byte),
	.dout_status (dout.status),
	.dout_last   (dout.last)
);
`default_nettype wire
